FILE: src/complex_arithmetic_unit_macros.svh
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/cau_pkg.sv
`default_nettype none
package cau_pkg;

    // operation codes
    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4
    } t_op;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic vld;
        t_op  op;
        logic dz;
    } t_ctl;

endpackage
`default_nettype wire

FILE: src/cau_div_cell.sv
`default_nettype none
module cau_div_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic                                i_neg,
    input  wire logic [2*DATA_WIDTH-1:0]             i_den,
    input  wire logic [2*DATA_WIDTH-1:0]             i_rem,
    input  wire logic [2*DATA_WIDTH+FRAC_BITS-1:0]   i_dvd,
    input  wire logic [DATA_WIDTH:0]                 i_q,
    input  wire logic                                i_big,
    output logic                                     o_neg,
    output logic [2*DATA_WIDTH-1:0]                  o_den,
    output logic [2*DATA_WIDTH-1:0]                  o_rem,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0]        o_dvd,
    output logic [DATA_WIDTH:0]                      o_q,
    output logic                                     o_big
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int NB = PW + FRAC_BITS;

    logic [PW:0]   w_trial;
    logic          w_ge;
    logic [PW:0]   w_diff;
    logic [PW-1:0] n_rem;

    // one restoring step: bring down a dividend bit, compare, subtract
    always_comb begin
        w_trial = {i_rem, i_dvd[NB-1]};
        w_ge    = (w_trial >= {1'b0, i_den});
        w_diff  = w_trial - {1'b0, i_den};
        n_rem   = w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_neg <= i_neg;
            o_den <= i_den;
            o_rem <= n_rem;
            o_dvd <= {i_dvd[NB-2:0], 1'b0};
            o_q   <= {i_q[DATA_WIDTH-1:0], w_ge};
            o_big <= i_big | i_q[DATA_WIDTH];
        end
    end
endmodule
`default_nettype wire

FILE: src/cau_sqrt_cell.sv
`default_nettype none
module cau_sqrt_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [2*DATA_WIDTH-1:0]   i_rad,
    input  wire logic [DATA_WIDTH:0]       i_rem,
    input  wire logic [DATA_WIDTH-1:0]     i_root,
    output logic [2*DATA_WIDTH-1:0]        o_rad,
    output logic [DATA_WIDTH:0]            o_rem,
    output logic [DATA_WIDTH-1:0]          o_root
);
    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;

    logic [DW+2:0] w_acc;
    logic [DW+2:0] w_trial;
    logic          w_ge;
    logic [DW+2:0] w_diff;

    // one root digit: bring down two radicand bits, try 4*root+1
    always_comb begin
        w_acc   = {i_rem, i_rad[PW-1:PW-2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_ge    = (w_acc >= w_trial);
        w_diff  = w_acc - w_trial;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[PW-3:0], 2'b00};
            o_rem  <= w_ge ? w_diff[DW:0] : w_acc[DW:0];
            o_root <= {i_root[DW-2:0], w_ge};
        end
    end
endmodule
`default_nettype wire

FILE: src/complex_arithmetic_unit.sv
// throughput: one item per cycle; the pipeline holds as a whole while a result is not taken
// depth is set by the restoring divider, one cell per quotient bit; the root chain runs beside
// it; a 32x32 multiplier stage and a combine stage come first
// reset (synchronous, active low) clears the valid bits of every stage
`default_nettype none
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [31:0] i_a_re,
    input  wire logic signed [31:0] i_a_im,
    input  wire logic signed [31:0] i_b_re,
    input  wire logic signed [31:0] i_b_im,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_res_re,
    output logic signed [31:0]      o_res_im,
    output logic                    o_div_zero,
    output logic                    o_saturated
);
    import cau_pkg::*;
    `include "complex_arithmetic_unit_macros.svh"

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DW;
    localparam int NB   = PW + FRAC_BITS;
    localparam int NDIV = NB;
    localparam int NPAD = NDIV - DW;
    localparam logic [PW:0] LIM_POS = {{(PW - DW + 2){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic [PW:0] LIM_NEG = LIM_POS + 1'b1;

    // sign and magnitude of a wide signed value
    function automatic logic [PW+1:0] to_sm(input logic signed [PW:0] v);
        logic [PW:0] m;
        m = v[PW] ? (PW+1)'(-v) : v;
        return {v[PW], m};
    endfunction

    // clamp a sign-magnitude value, result is {sat, value}
    function automatic logic [DW:0] clampf(input logic neg, input logic [PW:0] mag);
        logic [DW-1:0] v;
        logic          s;
        s = 1'b0;
        if (!neg && mag > LIM_POS) begin
            s = 1'b1;
            v = LIM_POS[DW-1:0];
        end else if (neg && mag > LIM_NEG) begin
            s = 1'b1;
            v = LIM_NEG[DW-1:0];
        end else begin
            v = neg ? DW'(-mag[DW-1:0]) : mag[DW-1:0];
        end
        return {s, v};
    endfunction

    logic en;
    logic r_out_vld;

    // whole pipeline moves unless the result waits
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // ---------------- stage 1: products and sums
    logic signed [DW-1:0] w_ar, w_ai, w_br, w_bi, w_m4, w_m5;
    logic signed [DW:0]   n_sre, n_sim;
    t_ctl                 r_s1_ctl;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DW:0]   r_sre, r_sim;

    // operand selection and add or subtract
    always_comb begin
        w_ar = i_a_re[DW-1:0];
        w_ai = i_a_im[DW-1:0];
        w_br = i_b_re[DW-1:0];
        w_bi = i_b_im[DW-1:0];
        w_m4 = (i_op == OP_MAG) ? w_ar : w_br;
        w_m5 = (i_op == OP_MAG) ? w_ai : w_bi;
        if (i_op == OP_SUB) begin
            n_sre = {w_ar[DW-1], w_ar} - {w_br[DW-1], w_br};
            n_sim = {w_ai[DW-1], w_ai} - {w_bi[DW-1], w_bi};
        end else begin
            n_sre = {w_ar[DW-1], w_ar} + {w_br[DW-1], w_br};
            n_sim = {w_ai[DW-1], w_ai} + {w_bi[DW-1], w_bi};
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl.vld <= 1'b0;
        end else if (en) begin
            r_s1_ctl <= '{vld: i_valid, op: t_op'(i_op), dz: 1'b0};
        end
    end

    // stage 1 products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0  <= PW'(w_ar) * PW'(w_br);
            r_p1  <= PW'(w_ai) * PW'(w_bi);
            r_p2  <= PW'(w_ar) * PW'(w_bi);
            r_p3  <= PW'(w_ai) * PW'(w_br);
            r_p4  <= PW'(w_m4) * PW'(w_m4);
            r_p5  <= PW'(w_m5) * PW'(w_m5);
            r_sre <= n_sre;
            r_sim <= n_sim;
        end
    end

    // ---------------- stage 2: combine, sign-magnitude, early results
    logic [PW+1:0]  w_smx, w_smy, w_dsx, w_dsy;
    logic [PW-1:0]  w_den;
    logic [DW:0]    w_cre, w_cim;
    logic [DW-1:0]  n_pre_re, n_pre_im;
    logic           n_pre_sat;
    t_ctl           n_s2_ctl;

    always_comb begin
        w_den = r_p4 + r_p5;
        w_dsx = to_sm((PW+1)'(r_p0) + (PW+1)'(r_p1));
        w_dsy = to_sm((PW+1)'(r_p3) - (PW+1)'(r_p2));
        w_smx = '0;
        w_smy = '0;
        w_cre = '0;
        w_cim = '0;
        unique case (r_s1_ctl.op) inside
            OP_ADD, OP_SUB: begin
                w_smx = to_sm((PW+1)'(r_sre));
                w_smy = to_sm((PW+1)'(r_sim));
                w_cre = clampf(w_smx[PW+1], w_smx[PW:0]);
                w_cim = clampf(w_smy[PW+1], w_smy[PW:0]);
            end
            OP_MUL: begin
                w_smx = to_sm((PW+1)'(r_p0) - (PW+1)'(r_p1));
                w_smy = to_sm((PW+1)'(r_p2) + (PW+1)'(r_p3));
                w_cre = clampf(w_smx[PW+1], w_smx[PW:0] >> FRAC_BITS);
                w_cim = clampf(w_smy[PW+1], w_smy[PW:0] >> FRAC_BITS);
            end
            default: begin
                w_cre = '0;
                w_cim = '0;
            end
        endcase
        n_pre_re  = w_cre[DW-1:0];
        n_pre_im  = w_cim[DW-1:0];
        n_pre_sat = w_cre[DW] | w_cim[DW];
        n_s2_ctl  = r_s1_ctl;
        n_s2_ctl.dz = (r_s1_ctl.op == OP_DIV) && (w_den == '0);
    end

    t_ctl           r_s2_ctl;
    logic [DW-1:0]  r_s2_pre_re, r_s2_pre_im;
    logic           r_s2_pre_sat;
    logic           r_s2_xneg, r_s2_yneg;
    logic [PW-1:0]  r_s2_xmag, r_s2_ymag, r_s2_den;

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl.vld <= 1'b0;
        end else if (en) begin
            r_s2_ctl <= n_s2_ctl;
        end
    end

    // stage 2 payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_pre_re  <= n_pre_re;
            r_s2_pre_im  <= n_pre_im;
            r_s2_pre_sat <= n_pre_sat;
            r_s2_xneg    <= w_dsx[PW+1];
            r_s2_yneg    <= w_dsy[PW+1];
            r_s2_xmag    <= w_dsx[PW-1:0];
            r_s2_ymag    <= w_dsy[PW-1:0];
            r_s2_den     <= w_den;
        end
    end

    // ---------------- divider chains, one per part
    logic           w_xneg [NDIV+1];
    logic [PW-1:0]  w_xden [NDIV+1];
    logic [PW-1:0]  w_xrem [NDIV+1];
    logic [NB-1:0]  w_xdvd [NDIV+1];
    logic [DW:0]    w_xq   [NDIV+1];
    logic           w_xbig [NDIV+1];
    logic           w_yneg [NDIV+1];
    logic [PW-1:0]  w_yden [NDIV+1];
    logic [PW-1:0]  w_yrem [NDIV+1];
    logic [NB-1:0]  w_ydvd [NDIV+1];
    logic [DW:0]    w_yq   [NDIV+1];
    logic           w_ybig [NDIV+1];

    assign w_xneg[0] = r_s2_xneg;
    assign w_xden[0] = r_s2_den;
    assign w_xrem[0] = '0;
    assign w_xdvd[0] = {r_s2_xmag, {FRAC_BITS{1'b0}}};
    assign w_xq[0]   = '0;
    assign w_xbig[0] = 1'b0;
    assign w_yneg[0] = r_s2_yneg;
    assign w_yden[0] = r_s2_den;
    assign w_yrem[0] = '0;
    assign w_ydvd[0] = {r_s2_ymag, {FRAC_BITS{1'b0}}};
    assign w_yq[0]   = '0;
    assign w_ybig[0] = 1'b0;

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        cau_div_cell #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_xcell (
            .i_clk (i_clk),      .i_en  (en),
            .i_neg (w_xneg[k]),  .i_den (w_xden[k]),  .i_rem (w_xrem[k]),
            .i_dvd (w_xdvd[k]),  .i_q   (w_xq[k]),    .i_big (w_xbig[k]),
            .o_neg (w_xneg[k+1]), .o_den (w_xden[k+1]), .o_rem (w_xrem[k+1]),
            .o_dvd (w_xdvd[k+1]), .o_q   (w_xq[k+1]),   .o_big (w_xbig[k+1])
        );
        cau_div_cell #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_ycell (
            .i_clk (i_clk),      .i_en  (en),
            .i_neg (w_yneg[k]),  .i_den (w_yden[k]),  .i_rem (w_yrem[k]),
            .i_dvd (w_ydvd[k]),  .i_q   (w_yq[k]),    .i_big (w_ybig[k]),
            .o_neg (w_yneg[k+1]), .o_den (w_yden[k+1]), .o_rem (w_yrem[k+1]),
            .o_dvd (w_ydvd[k+1]), .o_q   (w_yq[k+1]),   .o_big (w_ybig[k+1])
        );
    end

    // ---------------- square root chain
    logic [PW-1:0] w_rad  [DW+1];
    logic [DW:0]   w_srem [DW+1];
    logic [DW-1:0] w_root [DW+1];

    assign w_rad[0]  = r_s2_den;
    assign w_srem[0] = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_sqrt
        cau_sqrt_cell #(.DATA_WIDTH(DW)) u_scell (
            .i_clk  (i_clk),       .i_en   (en),
            .i_rad  (w_rad[k]),    .i_rem  (w_srem[k]),   .i_root (w_root[k]),
            .o_rad  (w_rad[k+1]),  .o_rem  (w_srem[k+1]), .o_root (w_root[k+1])
        );
    end

    // root waits for the divider to finish
    logic [DW-1:0] r_root_dl [NPAD];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_root_dl[0] <= w_root[DW];
            for (int k = 1; k < NPAD; k++) begin
                r_root_dl[k] <= r_root_dl[k-1];
            end
        end
    end

    // ---------------- control and early results ride beside the divider
    t_ctl          r_ctl_dl    [NDIV];
    logic [DW-1:0] r_pre_re_dl [NDIV];
    logic [DW-1:0] r_pre_im_dl [NDIV];
    logic          r_pre_sat_dl[NDIV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NDIV; k++) begin
                r_ctl_dl[k].vld <= 1'b0;
            end
        end else if (en) begin
            r_ctl_dl[0] <= r_s2_ctl;
            for (int k = 1; k < NDIV; k++) begin
                r_ctl_dl[k] <= r_ctl_dl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_re_dl[0]  <= r_s2_pre_re;
            r_pre_im_dl[0]  <= r_s2_pre_im;
            r_pre_sat_dl[0] <= r_s2_pre_sat;
            for (int k = 1; k < NDIV; k++) begin
                r_pre_re_dl[k]  <= r_pre_re_dl[k-1];
                r_pre_im_dl[k]  <= r_pre_im_dl[k-1];
                r_pre_sat_dl[k] <= r_pre_sat_dl[k-1];
            end
        end
    end

    // ---------------- final select and clamp
    t_ctl          w_lctl;
    logic [PW:0]   w_qx, w_qy;
    logic [DW:0]   w_fre, w_fim;
    logic [DW-1:0] n_res_re, n_res_im;
    logic          n_sat, n_dz;

    always_comb begin
        w_lctl   = r_ctl_dl[NDIV-1];
        w_qx     = w_xbig[NDIV] ? '1 : {{DW{1'b0}}, w_xq[NDIV]};
        w_qy     = w_ybig[NDIV] ? '1 : {{DW{1'b0}}, w_yq[NDIV]};
        w_fre    = '0;
        w_fim    = '0;
        n_res_re = r_pre_re_dl[NDIV-1];
        n_res_im = r_pre_im_dl[NDIV-1];
        n_sat    = r_pre_sat_dl[NDIV-1];
        n_dz     = 1'b0;
        unique case (w_lctl.op)
            OP_DIV: begin
                if (w_lctl.dz) begin
                    n_res_re = '0;
                    n_res_im = '0;
                    n_sat    = 1'b0;
                    n_dz     = 1'b1;
                end else begin
                    w_fre    = clampf(w_xneg[NDIV], w_qx);
                    w_fim    = clampf(w_yneg[NDIV], w_qy);
                    n_res_re = w_fre[DW-1:0];
                    n_res_im = w_fim[DW-1:0];
                    n_sat    = w_fre[DW] | w_fim[DW];
                end
            end
            OP_MAG: begin
                w_fre    = clampf(1'b0, {{(PW + 1 - DW){1'b0}}, r_root_dl[NPAD-1]});
                n_res_re = w_fre[DW-1:0];
                n_res_im = '0;
                n_sat    = w_fre[DW];
            end
            default: begin
                w_fre = '0;
                w_fim = '0;
            end
        endcase
    end

    // output register
    logic signed [DW-1:0] r_res_re, r_res_im;
    logic                 r_dz, r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_lctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_dz     <= n_dz;
            r_sat    <= n_sat;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_res_re    = 32'(r_res_re);
    assign o_res_im    = 32'(r_res_im);
    assign o_div_zero  = r_dz;
    assign o_saturated = r_sat;

    // ---------------- assertions
    `CAU_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, o_valid && o_div_zero,
        o_res_re == 32'sd0 && o_res_im == 32'sd0 && !o_saturated)
    `CAU_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, o_valid && !i_ready, !o_ready)
    `CAU_ASSERT_NXT(a_s1_load, i_clk, i_rst_n, o_ready, r_s1_ctl.vld == $past(i_valid))
endmodule
`default_nettype wire
